// ===== src/nlc_pkg.sv =====
// shared types, character codes and the printf specifier table for the literal classifier
package nlc_pkg;

    localparam int SPEC_BUFFER_CHARS_DEFAULT = 4;
    localparam int SPEC_COUNT = 24;
    localparam int SPEC_MAX   = 4;
    localparam int POS_W      = 3;
    localparam int CLASS_W    = 7;

    // class bits in the alive vector
    localparam int CL_DS = 0;
    localparam int CL_DU = 1;
    localparam int CL_OS = 2;
    localparam int CL_OU = 3;
    localparam int CL_HS = 4;
    localparam int CL_HU = 5;
    localparam int CL_FL = 6;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LK    = 8'h6b;
    localparam logic [7:0] CH_UK    = 8'h4b;
    localparam logic [7:0] CH_LM    = 8'h6d;
    localparam logic [7:0] CH_UM    = 8'h4d;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_string;
    } t_char_req;

    typedef struct packed {
        logic is_dec_signed;
        logic is_dec_unsigned;
        logic is_oct_signed;
        logic is_oct_unsigned;
        logic is_hex_signed;
        logic is_hex_unsigned;
        logic is_float_text;
        logic is_kilo_unsigned;
        logic is_mega_unsigned;
        logic is_format_spec;
    } t_flags;

    // candidate specifier: characters right-justified, zero above
    typedef struct packed {
        logic [8*SPEC_MAX-1:0] text;
        logic [POS_W-1:0]      len;
    } t_spec_key;

    localparam logic [8*SPEC_MAX-1:0] SPEC_TEXT [SPEC_COUNT] = '{
        "%c",   "%hhd", "%hhi", "%hd",  "%hi",  "%d",  "%i",  "%ld",
        "%li",  "%f",   "%lf",  "%hhx", "%hho", "%hhu", "%uc", "%hx",
        "%ho",  "%hu",  "%x",   "%o",   "%u",   "%lx", "%lo", "%lu"
    };

    localparam logic [POS_W-1:0] SPEC_LEN [SPEC_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3,
        3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3
    };

endpackage

// ===== src/numeric_literal_classifier.sv =====
// top level of the numeric literal classifier: input register, recognizer, result register
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  char in  | i_in_valid / o_in_stall    | i_char_code, i_last_char, i_empty_string
//  flags out| o_out_valid / i_out_stall  | o_is_dec_signed .. o_is_format_spec
//
//  one character request per cycle while o_in_stall is low; the request that ends a
//  string yields its result through the input register, then the result register
//  reset is synchronous, active low, and clears both stage valids and the recognizer
//  a stalled result holds the result register; requests that end no string keep
//  flowing, a string-ending request waits in the input register until the result
//  register frees up
module numeric_literal_classifier import nlc_pkg::*; #(
    parameter int SPEC_BUFFER_CHARS = SPEC_BUFFER_CHARS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character requests
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_empty_string,
    // match flags
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_dec_signed,
    output logic       o_is_dec_unsigned,
    output logic       o_is_oct_signed,
    output logic       o_is_oct_unsigned,
    output logic       o_is_hex_signed,
    output logic       o_is_hex_unsigned,
    output logic       o_is_float_text,
    output logic       o_is_kilo_unsigned,
    output logic       o_is_mega_unsigned,
    output logic       o_is_format_spec
);

    // input register
    logic      r_in_valid;
    t_char_req r_in;

    // result register
    logic      r_out_valid;
    t_flags    r_out_flags;

    logic      has_result;
    logic      out_free;
    logic      proc;
    logic      in_take;
    t_flags    flags;

    // a request that ends a string needs room in the result register
    assign has_result = r_in.last_char | r_in.empty_string;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    nlc_recognizer #(
        .SPEC_BUFFER_CHARS (SPEC_BUFFER_CHARS)
    ) u_recognizer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (proc),
        .i_req     (r_in),
        .o_flags   (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // input stage refills whenever it empties or moves on
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            // result stage
            if (proc && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.char_code    <= i_char_code;
            r_in.last_char    <= i_last_char;
            r_in.empty_string <= i_empty_string;
        end
        if (proc && has_result) begin
            r_out_flags <= flags;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_dec_signed    = r_out_flags.is_dec_signed;
    assign o_is_dec_unsigned  = r_out_flags.is_dec_unsigned;
    assign o_is_oct_signed    = r_out_flags.is_oct_signed;
    assign o_is_oct_unsigned  = r_out_flags.is_oct_unsigned;
    assign o_is_hex_signed    = r_out_flags.is_hex_signed;
    assign o_is_hex_unsigned  = r_out_flags.is_hex_unsigned;
    assign o_is_float_text    = r_out_flags.is_float_text;
    assign o_is_kilo_unsigned = r_out_flags.is_kilo_unsigned;
    assign o_is_mega_unsigned = r_out_flags.is_mega_unsigned;
    assign o_is_format_spec   = r_out_flags.is_format_spec;

`ifndef SYNTH
    // a string-ending request that moves on always shows up as a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && has_result) |=> r_out_valid)
        else $error("string end did not produce a result");

    // stall on the input side only while a request is held
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // an empty string gives all flags clear
    a_empty_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in.empty_string) |=> (r_out_flags == '0))
        else $error("empty string produced a set flag");

    // suffix flags are exclusive
    a_suffix_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_kilo_unsigned && o_is_mega_unsigned))
        else $error("kilo and mega both set");

    // an unsigned decimal is also a signed decimal
    a_dec_nesting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_dec_unsigned) |-> o_is_dec_signed)
        else $error("unsigned decimal without signed decimal");
`endif

endmodule

// ===== src/nlc_spec_match.sv =====
// exact match of a short string against the printf specifier table
module nlc_spec_match import nlc_pkg::*; (
    input  t_spec_key i_key,
    output logic      o_match
);

    always_comb begin
        o_match = 1'b0;
        for (int k = 0; k < SPEC_COUNT; k++) begin
            if (SPEC_LEN[k] == i_key.len && SPEC_TEXT[k] == i_key.text) begin
                o_match = 1'b1;
            end
        end
    end

endmodule

// ===== src/nlc_recognizer.sv =====
// running recognizer state and per-character flag logic for the literal classifier
module nlc_recognizer import nlc_pkg::*; #(
    parameter int SPEC_BUFFER_CHARS = SPEC_BUFFER_CHARS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_char_req i_req,
    output t_flags    o_flags
);

    logic [POS_W-1:0]   r_pos;
    logic               r_minus;
    logic [CLASS_W-1:0] r_alive;
    logic [1:0]         r_dots;
    logic               r_lzp;
    logic               r_prefix_ok;
    logic [7:0]         r_spec [SPEC_BUFFER_CHARS];

    logic [POS_W-1:0]   n_pos;
    logic               n_minus;
    logic [CLASS_W-1:0] n_alive;
    logic [1:0]         n_dots;
    logic               n_lzp;
    logic               n_prefix_ok;

    logic [7:0]       c;
    logic             dg, oc, hx;
    logic             first_minus;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] lenr;
    logic [7:0]       cand [SPEC_MAX];
    t_spec_key        key;
    logic             spec_hit;

    assign c  = i_req.char_code;
    assign dg = (c >= CH_ZERO) && (c <= CH_NINE);
    assign oc = (c >= CH_ZERO) && (c <= CH_SEVEN);
    assign hx = dg || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)
             || c == CH_LX || c == CH_UX;
    assign first_minus = (r_pos == '0) && (c == CH_MINUS);
    assign j = r_pos - {{(POS_W-1){1'b0}}, r_minus};

    always_comb begin
        n_alive = r_alive;
        n_minus = r_minus;
        n_dots  = r_dots;
        n_lzp   = r_lzp;

        // unsigned classes count from the first character
        if (r_pos == '0) begin
            if (!dg || c == CH_ZERO) n_alive[CL_DU] = 1'b0;
            if (c != CH_ZERO) begin
                n_alive[CL_OU] = 1'b0;
                n_alive[CL_HU] = 1'b0;
            end
        end else begin
            if (!dg) n_alive[CL_DU] = 1'b0;
            if (!oc) n_alive[CL_OU] = 1'b0;
            if (r_pos == 3'd1) begin
                if (c != CH_LX) n_alive[CL_HU] = 1'b0;
            end else if (!hx) begin
                n_alive[CL_HU] = 1'b0;
            end
        end

        // signed classes and float count after an optional minus
        if (first_minus) begin
            n_minus = 1'b1;
        end else begin
            if (!dg || (j != '0 && r_lzp)) n_alive[CL_DS] = 1'b0;
            if (j == '0) begin
                if (c != CH_ZERO) begin
                    n_alive[CL_OS] = 1'b0;
                    n_alive[CL_HS] = 1'b0;
                end
            end else begin
                if (!oc) n_alive[CL_OS] = 1'b0;
                if (j == 3'd1) begin
                    if (c != CH_LX) n_alive[CL_HS] = 1'b0;
                end else if (!hx) begin
                    n_alive[CL_HS] = 1'b0;
                end
            end
            if (c == CH_DOT) begin
                if (r_dots != 2'd3) n_dots = r_dots + 2'd1;
            end else if (!dg) begin
                n_alive[CL_FL] = 1'b0;
            end
            if (j == 3'd1 && r_lzp && c != CH_DOT) n_alive[CL_FL] = 1'b0;
            if (j == '0 && c == CH_ZERO) n_lzp = 1'b1;
        end

        n_pos = (r_pos != 3'd7) ? r_pos + 3'd1 : 3'd7;
        lenr  = n_pos - {{(POS_W-1){1'b0}}, n_minus};
        n_prefix_ok = n_alive[CL_DU] || n_alive[CL_OU] || (n_alive[CL_HU] && n_pos >= 3'd2);
    end

    // specifier candidate: stored characters then the current one
    always_comb begin
        for (int m = 0; m < SPEC_MAX; m++) begin
            cand[m] = (3'(m) < r_pos) ? r_spec[m] : c;
        end
        key.len = n_pos;
        case (n_pos)
            3'd1:    key.text = {24'd0, cand[0]};
            3'd2:    key.text = {16'd0, cand[0], cand[1]};
            3'd3:    key.text = {8'd0, cand[0], cand[1], cand[2]};
            3'd4:    key.text = {cand[0], cand[1], cand[2], cand[3]};
            default: key.text = '0;
        endcase
    end

    nlc_spec_match u_spec_match (
        .i_key   (key),
        .o_match (spec_hit)
    );

    always_comb begin
        o_flags = '0;
        if (!i_req.empty_string) begin
            o_flags.is_dec_signed    = n_alive[CL_DS] && lenr >= 3'd1;
            o_flags.is_dec_unsigned  = n_alive[CL_DU];
            o_flags.is_oct_signed    = n_alive[CL_OS] && lenr >= 3'd2;
            o_flags.is_oct_unsigned  = n_alive[CL_OU];
            o_flags.is_hex_signed    = n_alive[CL_HS] && lenr >= 3'd3;
            o_flags.is_hex_unsigned  = n_alive[CL_HU] && n_pos >= 3'd2;
            o_flags.is_float_text    = n_alive[CL_FL] && n_dots <= 2'd1
                                    && !(n_lzp && lenr == 3'd1);
            o_flags.is_kilo_unsigned = (c == CH_LK || c == CH_UK) && r_prefix_ok;
            o_flags.is_mega_unsigned = (c == CH_LM || c == CH_UM) && r_prefix_ok;
            o_flags.is_format_spec   = spec_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_minus     <= 1'b0;
            r_alive     <= '1;
            r_dots      <= '0;
            r_lzp       <= 1'b0;
            r_prefix_ok <= 1'b0;
        end else if (i_advance) begin
            if (i_req.empty_string || i_req.last_char) begin
                r_pos       <= '0;
                r_minus     <= 1'b0;
                r_alive     <= '1;
                r_dots      <= '0;
                r_lzp       <= 1'b0;
                r_prefix_ok <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_minus     <= n_minus;
                r_alive     <= n_alive;
                r_dots      <= n_dots;
                r_lzp       <= n_lzp;
                r_prefix_ok <= n_prefix_ok;
            end
        end
    end

    // character buffer, only positions already written are read
    always_ff @(posedge i_clk) begin
        for (int e = 0; e < SPEC_BUFFER_CHARS; e++) begin
            if (i_advance && !i_req.empty_string && r_pos == 3'(e)) begin
                r_spec[e] <= c;
            end
        end
    end

endmodule
